// File: rtl/ilbm_body_byterun1_decoder_core_assert.svh
// Assertion macros for the ILBM body decoder checker.
// Clocking and reset come from the scope of the module that uses them (clk, rst_n).
`ifndef ILBM_BODY_BYTERUN1_DECODER_CORE_ASSERT_SVH
`define ILBM_BODY_BYTERUN1_DECODER_CORE_ASSERT_SVH

// Same-cycle implication
`define ILBM_BR1_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ILBM_BR1_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ilbm_br1_pkg.sv
// Shared types, codes and helpers for the ILBM body ByteRun1 decoder.
// No dependencies; every file but the assertion macro header imports this package.
package ilbm_br1_pkg;

  // Default for the colour plane ceiling
  localparam int MAX_PLANES_DEF = 8;

  // Fixed field widths
  localparam int COL_W       = 13;
  localparam int ROW_W       = 16;
  localparam int BPR_W       = 14;   // row bytes reach 8192
  localparam int PLANE_OUT_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0] RUN_MAX  = 8'd128;
  localparam logic [7:0] NOP_CODE = 8'h80;   // count byte -128

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 3'd4;

  // Compression modes
  localparam logic MODE_RAW      = 1'b0;
  localparam logic MODE_BYTERUN1 = 1'b1;

  // Status / error codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SHORT    = 2'd1;
  localparam logic [1:0] STAT_TRAILING = 2'd2;
  localparam logic [1:0] STAT_OVERRUN  = 2'd3;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_LITERAL,
    PH_REPEAT,
    PH_DROP
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             out_value;
    logic [7:0]             run_length;
    logic [PLANE_OUT_W-1:0] out_plane;
    logic [ROW_W-1:0]       out_row;
    logic [COL_W-1:0]       out_column;
    logic                   done_res;
    logic [1:0]             status;
  } out_item_t;

  // Effective image geometry, derived from the configuration registers
  typedef struct packed {
    logic             mode;
    logic [BPR_W-1:0] row_bytes;
    logic [ROW_W-1:0] height;
  } cfg_view_t;

  // Decoder state apart from the plane index (its width follows MAX_PLANES)
  typedef struct packed {
    parse_phase_t     phase;
    logic [7:0]       literal_left;
    logic [7:0]       repeat_length;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             complete;
    logic [1:0]       error;
  } dec_state_t;

  // First error seen sticks
  function automatic logic [1:0] set_err(logic [1:0] cur, logic [1:0] code);
    return (cur == STAT_OK) ? code : cur;
  endfunction

endpackage

// File: rtl/ilbm_br1_cfg.sv
// Configuration registers and derived image geometry.
// Depends on ilbm_br1_pkg.
module ilbm_br1_cfg #(
  parameter int MAX_PLANES = ilbm_br1_pkg::MAX_PLANES_DEF,
  localparam int PLANE_W = $clog2(MAX_PLANES + 2)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ilbm_br1_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ilbm_br1_pkg::CFG_DATA_W-1:0] cfg_data,
  output ilbm_br1_pkg::cfg_view_t             cfg_view,
  output logic [PLANE_W-1:0]                  colour_planes,
  output logic [PLANE_W-1:0]                  plane_total
);
  import ilbm_br1_pkg::*;

  logic        mode_r;
  logic        mask_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [3:0]  planes_r;

  logic [15:0] width_eff;
  logic [11:0] words;
  logic [3:0]  planes_eff;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BYTERUN1;
      mask_r   <= 1'b0;
      width_r  <= 16'd320;
      height_r <= 16'd200;
      planes_r <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_MASK:   mask_r   <= cfg_data[0];
        CFG_WIDTH:  width_r  <= cfg_data[15:0];
        CFG_HEIGHT: height_r <= cfg_data[15:0];
        CFG_PLANES: planes_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Row bytes: width rounded up to 16-pixel words, two bytes per word
  always_comb begin
    width_eff = (width_r == 16'd0) ? 16'd1 : width_r;
    words     = width_eff[15:4];
    cfg_view.mode      = mode_r;
    cfg_view.row_bytes = {({1'b0, words} + {12'd0, |width_eff[3:0]}), 1'b0};
    cfg_view.height    = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  // Colour planes clamped to 1..MAX_PLANES; mask plane adds one more slot
  always_comb begin
    planes_eff = (planes_r == 4'd0) ? 4'd1 : planes_r;
    if (int'(planes_eff) > MAX_PLANES) begin
      colour_planes = PLANE_W'(MAX_PLANES);
    end else begin
      colour_planes = PLANE_W'(planes_eff);
    end
    plane_total = colour_planes + PLANE_W'(mask_r);
  end

endmodule

// File: rtl/ilbm_br1_step.sv
// One-byte decode step: position normalise, raw or ByteRun1 parse, advance, result build.
// Purely combinational; depends on ilbm_br1_pkg.
module ilbm_br1_step #(
  parameter int MAX_PLANES = ilbm_br1_pkg::MAX_PLANES_DEF,
  localparam int PLANE_W = $clog2(MAX_PLANES + 2)
) (
  input  ilbm_br1_pkg::cfg_view_t  cfg_view,
  input  logic [PLANE_W-1:0]       colour_planes,
  input  logic [PLANE_W-1:0]       plane_total,
  input  ilbm_br1_pkg::in_item_t   item,
  input  ilbm_br1_pkg::dec_state_t st_cur,
  input  logic [PLANE_W-1:0]       plane_cur,
  output ilbm_br1_pkg::dec_state_t st_nxt,
  output logic [PLANE_W-1:0]       plane_nxt,
  output logic                     has_result,
  output ilbm_br1_pkg::out_item_t  result
);
  import ilbm_br1_pkg::*;

  // Normalised position at the start of the step
  logic [COL_W-1:0]   n_col;
  logic [PLANE_W-1:0] n_plane;
  logic [ROW_W-1:0]   n_row;
  logic               n_done;
  logic [PLANE_W-1:0] pl1;
  logic [ROW_W-1:0]   row1;

  // Parse outputs
  parse_phase_t p_phase;
  logic [7:0]   p_lit;
  logic [7:0]   p_rep;
  logic [1:0]   p_err;
  logic         emit;
  logic         adv_en;
  logic [7:0]   adv_k;

  // Advanced position
  logic [COL_W-1:0]   a_col;
  logic [PLANE_W-1:0] a_plane;
  logic [ROW_W-1:0]   a_row;
  logic               a_done;

  logic [BPR_W-1:0] remaining;
  logic             real_plane;
  logic [7:0]       lit_new;
  logic [7:0]       rep_new;
  logic [BPR_W-1:0] k_min;
  logic [7:0]       k_run;
  logic             hit_end;
  logic [1:0]       status;

  // Bring a stale position inside the current bounds
  always_comb begin
    n_col   = st_cur.column;
    n_plane = plane_cur;
    n_row   = st_cur.row;
    n_done  = st_cur.complete;
    pl1     = plane_cur;
    row1    = st_cur.row;
    if (!st_cur.complete) begin
      if ({1'b0, st_cur.column} >= cfg_view.row_bytes) begin
        n_col = '0;
        pl1   = plane_cur + PLANE_W'(1);
      end
      n_plane = pl1;
      if (pl1 >= plane_total) begin
        n_plane = '0;
        row1    = st_cur.row + ROW_W'(1);
      end
      n_row = row1;
      if (row1 >= cfg_view.height) begin
        n_row   = '0;
        n_plane = '0;
        n_col   = '0;
        n_done  = 1'b1;
      end
    end
  end

  // Shared arithmetic on the normalised position
  always_comb begin
    remaining  = cfg_view.row_bytes - {1'b0, n_col};
    real_plane = (n_plane < colour_planes);
    lit_new    = {1'b0, item.in_byte[6:0]} + 8'd1;
    rep_new    = 8'(9'd257 - {1'b0, item.in_byte});
    k_min      = ({6'd0, st_cur.repeat_length} < remaining) ?
                 {6'd0, st_cur.repeat_length} : remaining;
    k_run      = (k_min == '0) ? 8'd1 : k_min[7:0];
  end

  // Parser: raw bytes, or ByteRun1 count / literal / repeat / drop phases
  always_comb begin
    p_phase = st_cur.phase;
    p_lit   = st_cur.literal_left;
    p_rep   = st_cur.repeat_length;
    p_err   = st_cur.error;
    emit    = 1'b0;
    adv_en  = 1'b0;
    adv_k   = 8'd1;
    if (n_done) begin
      // Image already full: raw and count bytes are trailing, open runs drain quietly
      if (cfg_view.mode == MODE_RAW || st_cur.phase == PH_COUNT) begin
        p_err = set_err(st_cur.error, STAT_TRAILING);
      end else if (st_cur.phase == PH_REPEAT) begin
        p_phase = PH_COUNT;
      end else if (st_cur.literal_left <= 8'd1) begin
        p_lit   = 8'd0;
        p_phase = PH_COUNT;
      end else begin
        p_lit = st_cur.literal_left - 8'd1;
      end
    end else if (cfg_view.mode == MODE_RAW) begin
      emit   = real_plane;
      adv_en = 1'b1;
    end else begin
      unique case (st_cur.phase)
        PH_COUNT: begin
          if (!item.in_byte[7]) begin
            p_lit   = lit_new;
            p_phase = PH_LITERAL;
            if ({6'd0, lit_new} > remaining) p_err = set_err(st_cur.error, STAT_OVERRUN);
          end else if (item.in_byte != NOP_CODE) begin
            p_rep   = rep_new;
            p_phase = PH_REPEAT;
            if ({6'd0, rep_new} > remaining) p_err = set_err(st_cur.error, STAT_OVERRUN);
          end
        end
        PH_LITERAL: begin
          emit   = real_plane;
          adv_en = 1'b1;
          if (st_cur.literal_left <= 8'd1) begin
            p_lit   = 8'd0;
            p_phase = PH_COUNT;
          end else begin
            p_lit = st_cur.literal_left - 8'd1;
            if (remaining == BPR_W'(1)) p_phase = PH_DROP;
          end
        end
        PH_REPEAT: begin
          emit    = real_plane;
          adv_en  = 1'b1;
          adv_k   = k_run;
          p_phase = PH_COUNT;
          p_rep   = 8'd0;
        end
        PH_DROP: begin
          // literal bytes clipped at the row end
          if (st_cur.literal_left <= 8'd1) begin
            p_lit   = 8'd0;
            p_phase = PH_COUNT;
          end else begin
            p_lit = st_cur.literal_left - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the position; a step never goes beyond the row end
  always_comb begin
    hit_end = ({6'd0, adv_k} == remaining);
    a_col   = n_col;
    a_plane = n_plane;
    a_row   = n_row;
    a_done  = n_done;
    if (adv_en) begin
      if (hit_end) begin
        a_col = '0;
        if (n_plane + PLANE_W'(1) >= plane_total) begin
          a_plane = '0;
          if ({1'b0, n_row} + 17'd1 >= {1'b0, cfg_view.height}) begin
            a_row  = '0;
            a_done = 1'b1;
          end else begin
            a_row = n_row + ROW_W'(1);
          end
        end else begin
          a_plane = n_plane + PLANE_W'(1);
        end
      end else begin
        a_col = COL_W'({1'b0, n_col} + {6'd0, adv_k});
      end
    end
  end

  // Result item and end-of-body status; last byte returns state to reset values
  always_comb begin
    if (p_err != STAT_OK) begin
      status = p_err;
    end else if (!a_done || (cfg_view.mode == MODE_BYTERUN1 && p_phase != PH_COUNT)) begin
      status = STAT_SHORT;
    end else begin
      status = STAT_OK;
    end

    has_result = emit || item.last;
    result     = '0;
    if (emit) begin
      result.out_value  = item.in_byte;
      result.run_length = adv_k;
      result.out_plane  = PLANE_OUT_W'(n_plane);
      result.out_row    = n_row;
      result.out_column = n_col;
    end
    result.done_res = item.last;
    result.status   = item.last ? status : STAT_OK;

    if (item.last) begin
      st_nxt    = '0;
      st_nxt.phase = PH_COUNT;
      st_nxt.error = STAT_OK;
      plane_nxt = '0;
    end else begin
      st_nxt.phase         = p_phase;
      st_nxt.literal_left  = p_lit;
      st_nxt.repeat_length = p_rep;
      st_nxt.row           = a_row;
      st_nxt.column        = a_col;
      st_nxt.complete      = a_done;
      st_nxt.error         = p_err;
      plane_nxt            = a_plane;
    end
  end

endmodule

// File: rtl/ilbm_body_byterun1_decoder_core.sv
// ILBM body decoder (raw or ByteRun1 rows) top level.
// Depends on ilbm_br1_pkg, ilbm_br1_cfg and ilbm_br1_step.
//
// Usage:
//   in_*  : one body byte per transfer, with a flag on the final byte.
//   out_* : run descriptors (value, length 1..128, plane, row, byte column);
//           the final byte always yields one item with done_res set and the
//           body status. Mask plane data and count bytes give no item.
//   cfg_* : register writes (mode, mask, width, height, planes), always
//           ready; write only while no byte is in flight.
// Timing: a byte taken into the input register is decoded once the result
//   register is free or being emptied, and its run is offered on out_valid
//   from then on. One byte is taken every cycle while that holds; the limit
//   is the single decode stage that updates the position counters.
// Stalls: the input register and the result register are decoupled, so a
//   byte is taken while a result waits; when both are full, in_ready drops
//   until out_ready frees the result register.
// Reset: synchronous, active low; registers return to their defaults and
//   the decoder waits for the first count byte of a new body. After each
//   final byte the decoder returns to that same state by itself.
module ilbm_body_byterun1_decoder_core #(
  parameter int MAX_PLANES = ilbm_br1_pkg::MAX_PLANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ilbm_br1_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ilbm_br1_pkg::out_item_t             out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ilbm_br1_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ilbm_br1_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ilbm_br1_pkg::*;

  localparam int PLANE_W = $clog2(MAX_PLANES + 2);

  cfg_view_t          cfg_view;
  logic [PLANE_W-1:0] colour_planes;
  logic [PLANE_W-1:0] plane_total;

  logic               in_valid_r;
  in_item_t           in_data_r;
  dec_state_t         st_r;
  dec_state_t         st_nxt;
  logic [PLANE_W-1:0] plane_r;
  logic [PLANE_W-1:0] plane_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               has_result;
  out_item_t          result;
  logic               advance;

  ilbm_br1_cfg #(.MAX_PLANES(MAX_PLANES)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_view     (cfg_view),
    .colour_planes(colour_planes),
    .plane_total  (plane_total)
  );

  ilbm_br1_step #(.MAX_PLANES(MAX_PLANES)) u_step (
    .cfg_view     (cfg_view),
    .colour_planes(colour_planes),
    .plane_total  (plane_total),
    .item         (in_data_r),
    .st_cur       (st_r),
    .plane_cur    (plane_r),
    .st_nxt       (st_nxt),
    .plane_nxt    (plane_nxt),
    .has_result   (has_result),
    .result       (result)
  );

  // Decode proceeds when the result register is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '{phase: PH_COUNT, error: STAT_OK, default: '0};
      plane_r <= '0;
    end else if (advance) begin
      st_r    <= st_nxt;
      plane_r <= plane_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/ilbm_br1_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on ilbm_br1_pkg and the assertion macro header.
`include "ilbm_body_byterun1_decoder_core_assert.svh"

module ilbm_br1_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input ilbm_br1_pkg::out_item_t out_data
);
  import ilbm_br1_pkg::*;

  // A held result keeps its payload
  `ILBM_BR1_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Runs never exceed the ByteRun1 maximum
  `ILBM_BR1_ASSERT_IMP(a_run_max, out_valid, out_data.run_length <= RUN_MAX, "run length above 128")

  // Status only on the final result, and only the final result may be empty
  `ILBM_BR1_ASSERT_IMP(a_mid_item, out_valid && !out_data.done_res, out_data.status == STAT_OK && out_data.run_length != 8'd0, "bad mid-body result")

  // A status-only item carries a zero run descriptor
  `ILBM_BR1_ASSERT_IMP(a_empty_run, out_valid && out_data.run_length == 8'd0, out_data.out_value == 8'd0 && out_data.out_column == '0 && out_data.out_row == '0 && out_data.out_plane == '0, "status-only item has run fields")

endmodule

bind ilbm_body_byterun1_decoder_core ilbm_br1_checker u_ilbm_br1_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: tb/sv/tb_ilbm_body_byterun1_decoder_core.sv
// Self-checking bench for the ILBM body decoder: raw and ByteRun1 bodies, mask planes,
// row-end overruns, short and trailing bodies. Depends on ilbm_br1_pkg and the core;
// a run tracker class predicts each run descriptor and checks it on the result channel.
module tb_ilbm_body_byterun1_decoder_core;
  import ilbm_br1_pkg::*;

  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // hold-off plus random stalls, several times over
  localparam int DRAIN_CYCLES = 4;     // pipeline latency plus margin
  localparam int REGIME_ITEMS = 540;   // random bytes per idling regime

  typedef enum int {
    BODY_CLEAN,
    BODY_SHORT,
    BODY_TRAILING,
    BODY_OVERRUN,
    BODY_NOISE
  } body_kind_t;

  // Predicts run descriptors from accepted body bytes and checks the block's output
  class run_tracker;
    logic         mode;
    logic         mask;
    logic [15:0]  width;
    logic [15:0]  height;
    logic [3:0]   planes;
    parse_phase_t phase;
    int unsigned  literal_left;
    int unsigned  repeat_length;
    int unsigned  row;
    int unsigned  plane;
    int unsigned  column;
    bit           complete;
    logic [1:0]   err;
    out_item_t    pending_runs[$];
    int unsigned  fail_count;

    function new();
      mode       = MODE_BYTERUN1;
      mask       = 1'b0;
      width      = 16'd320;
      height     = 16'd200;
      planes     = 4'd5;
      fail_count = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase         = PH_COUNT;
      literal_left  = 0;
      repeat_length = 0;
      row           = 0;
      plane         = 0;
      column        = 0;
      complete      = 1'b0;
      err           = STAT_OK;
    endfunction

    // Plane row length in bytes, whole 16-pixel words
    function int unsigned row_bytes();
      int unsigned w;
      w = (width == 0) ? 1 : width;
      return ((w + 15) / 16) * 2;
    endfunction

    function int unsigned colour_planes();
      int unsigned p;
      p = (planes == 0) ? 1 : planes;
      return (p > MAX_PLANES_DEF) ? MAX_PLANES_DEF : p;
    endfunction

    // First error sticks
    function void flag_error(logic [1:0] code);
      if (err == STAT_OK) err = code;
    endfunction

    // Carry column into plane, plane into row, row into completion
    function void wrap_position();
      int unsigned h;
      h = (height == 0) ? 1 : height;
      if (complete) return;
      if (column >= row_bytes()) begin
        column = 0;
        plane++;
      end
      if (plane >= colour_planes() + mask) begin
        plane = 0;
        row++;
      end
      if (row >= h) begin
        row      = 0;
        plane    = 0;
        column   = 0;
        complete = 1'b1;
      end
    endfunction

    function void step_column(int unsigned k);
      column += k;
      wrap_position();
    endfunction

    function void drop_literal();
      if (literal_left <= 1) begin
        literal_left = 0;
        phase        = PH_COUNT;
      end else begin
        literal_left--;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:   mode   = val[0];
        CFG_MASK:   mask   = val[0];
        CFG_WIDTH:  width  = val;
        CFG_HEIGHT: height = val;
        CFG_PLANES: planes = val[3:0];
        default: ;
      endcase
    endfunction

    // Decode one accepted byte; queue the run it produces, if any
    function void take_byte(in_item_t item);
      bit          emit;
      bit          is_colour;
      int unsigned val, len, pl, rw, col, remaining, k;
      out_item_t   run;
      emit = 1'b0;
      val  = 0;
      len  = 0;
      pl   = 0;
      rw   = 0;
      col  = 0;
      wrap_position();
      if (complete) begin
        // bytes past the end of the image
        if (mode == MODE_RAW || phase == PH_COUNT) flag_error(STAT_TRAILING);
        else if (phase == PH_REPEAT) phase = PH_COUNT;
        else drop_literal();
      end else begin
        remaining = row_bytes() - column;
        is_colour = plane < colour_planes();
        pl  = plane;
        rw  = row;
        col = column;
        if (mode == MODE_RAW) begin
          if (is_colour) begin
            emit = 1'b1;
            val  = item.in_byte;
            len  = 1;
          end
          step_column(1);
        end else begin
          case (phase)
            PH_COUNT: begin
              if (item.in_byte < 8'd128) begin
                literal_left = item.in_byte + 1;
                if (literal_left > remaining) flag_error(STAT_OVERRUN);
                phase = PH_LITERAL;
              end else if (item.in_byte != NOP_CODE) begin
                repeat_length = 257 - item.in_byte;
                if (repeat_length > remaining) flag_error(STAT_OVERRUN);
                phase = PH_REPEAT;
              end
            end
            PH_LITERAL: begin
              if (is_colour) begin
                emit = 1'b1;
                val  = item.in_byte;
                len  = 1;
              end
              if (literal_left <= 1) begin
                literal_left = 0;
                phase        = PH_COUNT;
              end else begin
                literal_left--;
                if (remaining == 1) phase = PH_DROP;
              end
              step_column(1);
            end
            PH_REPEAT: begin
              // clipped at the row end, never empty
              k = (repeat_length < remaining) ? repeat_length : remaining;
              if (k == 0) k = 1;
              if (is_colour) begin
                emit = 1'b1;
                val  = item.in_byte;
                len  = k;
              end
              phase         = PH_COUNT;
              repeat_length = 0;
              step_column(k);
            end
            default: drop_literal();
          endcase
        end
      end

      if (!emit && !item.last) return;
      if (!emit) begin
        pl  = 0;
        rw  = 0;
        col = 0;
      end
      run.out_value  = 8'(val);
      run.run_length = 8'(len);
      run.out_plane  = PLANE_OUT_W'(pl);
      run.out_row    = ROW_W'(rw);
      run.out_column = COL_W'(col);
      run.done_res   = item.last;
      run.status     = STAT_OK;
      if (item.last) begin
        if (err != STAT_OK) run.status = err;
        else if (!complete || (mode == MODE_BYTERUN1 && phase != PH_COUNT))
          run.status = STAT_SHORT;
        clear_state();
      end
      pending_runs.push_back(run);
    endfunction

    // Compare one transferred result with the oldest prediction
    function void match_run(out_item_t got);
      out_item_t want;
      if (pending_runs.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected run: value %0d len %0d plane %0d row %0d col %0d done %0b st %0d",
                   got.out_value, got.run_length, got.out_plane, got.out_row,
                   got.out_column, got.done_res, got.status);
        return;
      end
      want = pending_runs.pop_front();
      if (got.out_value !== want.out_value || got.run_length !== want.run_length ||
          got.out_plane !== want.out_plane || got.out_row !== want.out_row ||
          got.out_column !== want.out_column || got.done_res !== want.done_res ||
          got.status !== want.status) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("run mismatch, expected: value %0d len %0d plane %0d row %0d col %0d done %0b st %0d",
                   want.out_value, want.run_length, want.out_plane, want.out_row,
                   want.out_column, want.done_res, want.status);
          $display("               actual: value %0d len %0d plane %0d row %0d col %0d done %0b st %0d",
                   got.out_value, got.run_length, got.out_plane, got.out_row,
                   got.out_column, got.done_res, got.status);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  run_tracker  board = new();
  logic [7:0]  body_bytes[$];
  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 47;
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles = 0;
  bit          hold_request = 1'b0;

  ilbm_body_byterun1_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transfer monitor: feeds the tracker and counts cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.take_byte(in_data);
      if (out_valid && out_ready) board.match_run(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Watchdog
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready    = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the write
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one body byte, with random gaps before it; valid holds until the transfer
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data.in_byte = b;
    in_data.last    = l;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Wait until every predicted run is out and the pipeline has emptied
  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_body();
    for (int i = 0; i < body_bytes.size(); i++)
      send_byte(body_bytes[i], i == body_bytes.size() - 1);
  endtask

  // One ByteRun1 run of n bytes: repeat or literal
  task automatic push_run(input int unsigned n, input bit rep);
    if (rep) begin
      body_bytes.push_back(8'(257 - n));
      body_bytes.push_back(8'($urandom_range(255)));
    end else begin
      body_bytes.push_back(8'(n - 1));
      repeat (n) body_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // Encode a body for the current geometry, then spoil it as the kind says
  task automatic build_body(input body_kind_t kind);
    int unsigned     bpr, prows, rows, cap, left, n, slot, bad_slot;
    longint unsigned full;
    bpr   = board.row_bytes();
    prows = board.colour_planes() + board.mask;
    rows  = (board.height == 0) ? 1 : board.height;
    full  = longint'(bpr) * prows * rows;
    cap   = (kind == BODY_SHORT) ? $urandom_range(1, 40) : 32'hFFFF_FFFF;
    if (full > 1200 && cap > 60) cap = $urandom_range(8, 60);
    bad_slot = (kind == BODY_OVERRUN) ? $urandom_range(7) : 32'hFFFF_FFFF;
    slot = 0;
    body_bytes.delete();
    if (kind == BODY_NOISE) begin
      repeat ($urandom_range(1, 30)) body_bytes.push_back(8'($urandom_range(255)));
    end else if (board.mode == MODE_RAW) begin
      while (body_bytes.size() < cap && body_bytes.size() < full)
        body_bytes.push_back(8'($urandom_range(255)));
    end else begin
      for (int r = 0; r < rows && body_bytes.size() < cap; r++) begin
        for (int p = 0; p < prows && body_bytes.size() < cap; p++) begin
          left = bpr;
          // one run that runs past the row end
          if (slot == bad_slot && left <= 126) begin
            push_run(left + $urandom_range(1, 2), $urandom_range(1) == 1);
            left = 0;
          end
          slot++;
          while (left > 0 && body_bytes.size() < cap) begin
            if ($urandom_range(15) == 0) body_bytes.push_back(NOP_CODE);
            n = $urandom_range(1, (left < 128) ? left : 128);
            push_run(n, (n >= 2) && ($urandom_range(1) == 1));
            left -= n;
          end
        end
      end
    end
    while (body_bytes.size() > cap) body_bytes.delete(body_bytes.size() - 1);
    if (kind == BODY_TRAILING)
      repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom_range(255)));
  endtask

  // New random geometry; mostly small images, now and then the extremes
  task automatic reshape();
    logic [15:0] w, h;
    case ($urandom_range(19))
      0:       w = 16'd0;
      1:       w = 16'hFFFF;
      2:       w = 16'($urandom_range(65535));
      default: w = 16'($urandom_range(1, 64));
    endcase
    case ($urandom_range(19))
      0:       h = 16'd0;
      1:       h = 16'hFFFF;
      default: h = 16'($urandom_range(1, 3));
    endcase
    program_reg(CFG_MODE, 16'(($urandom_range(3) != 0) ? MODE_BYTERUN1 : MODE_RAW));
    program_reg(CFG_MASK, 16'($urandom_range(1)));
    program_reg(CFG_WIDTH, w);
    program_reg(CFG_HEIGHT, h);
    program_reg(CFG_PLANES, 16'($urandom_range(15)));
  endtask

  function automatic body_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return BODY_CLEAN;
    if (r < 78) return BODY_SHORT;
    if (r < 86) return BODY_TRAILING;
    if (r < 94) return BODY_OVERRUN;
    return BODY_NOISE;
  endfunction

  initial begin
    int unsigned target;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset geometry: a 128-byte literal overruns the 40-byte plane row
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // Zero width, height and plane count act as one; mask plane present
    program_reg(CFG_WIDTH, 16'd0);
    program_reg(CFG_HEIGHT, 16'd0);
    program_reg(CFG_PLANES, 16'd0);
    program_reg(CFG_MASK, 16'd1);
    send_byte(NOP_CODE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    settle();

    // Count byte after the image is complete
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h05, 1'b1);
    settle();

    // Raw rows at the widest geometry, cut short
    program_reg(CFG_MODE, 16'(MODE_RAW));
    program_reg(CFG_WIDTH, 16'hFFFF);
    program_reg(CFG_HEIGHT, 16'hFFFF);
    program_reg(CFG_PLANES, 16'd15);
    program_reg(CFG_MASK, 16'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // Geometry and mode changed in the middle of a body
    program_reg(CFG_MODE, 16'(MODE_BYTERUN1));
    program_reg(CFG_WIDTH, 16'd32);
    program_reg(CFG_HEIGHT, 16'd1);
    program_reg(CFG_PLANES, 16'd8);
    send_byte(8'h03, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    settle();
    program_reg(CFG_WIDTH, 16'd16);
    send_byte(8'h33, 1'b0);
    settle();
    program_reg(CFG_MODE, 16'(MODE_RAW));
    send_byte(8'h44, 1'b0);
    settle();
    program_reg(CFG_MODE, 16'(MODE_BYTERUN1));
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
    settle();

    // Literal crossing the row end: the excess byte is dropped
    program_reg(CFG_HEIGHT, 16'd2);
    program_reg(CFG_PLANES, 16'd1);
    send_byte(8'h02, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hA2, 1'b0);
    send_byte(8'hA3, 1'b0);
    send_byte(8'h81, 1'b1);
    settle();

    // Random bodies under three idling regimes
    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 9 : (regime == 1) ? 47 : 0;
      recv_idle_pct = (regime == 0) ? 47 : (regime == 1) ? 9 : 0;
      target = bytes_sent + REGIME_ITEMS;
      if (regime == 2) begin
        // fill the block behind a long receiver hold-off
        settle();
        program_reg(CFG_MODE, 16'(MODE_BYTERUN1));
        program_reg(CFG_MASK, 16'd0);
        program_reg(CFG_WIDTH, 16'd64);
        program_reg(CFG_HEIGHT, 16'd2);
        program_reg(CFG_PLANES, 16'd4);
        hold_request = 1'b1;
        build_body(BODY_CLEAN);
        send_body();
      end
      while (bytes_sent < target) begin
        settle();
        if ($urandom_range(2) == 0) reshape();
        build_body(pick_kind());
        send_body();
      end
    end
    settle();

    if (board.fail_count == 0 && board.pending_runs.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
